// File: rtl/core/tfn_pkg.sv
// Shared constants for the triangle face normal core.
package tfn_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int OUT_BITS             = 16;
  localparam int NORM_BITS            = 31;
  localparam int SUM_BITS             = 64;
  localparam int ROOT_BITS            = 32;
  localparam int ROOT_STEPS           = 32;

endpackage

// File: rtl/core/tfn_tri_if.sv
// Triangle input channel: three vertices and a last flag.
interface tfn_tri_if #(
  parameter int CW = tfn_pkg::COORD_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] ax;
  logic [CW-1:0] ay;
  logic [CW-1:0] az;
  logic [CW-1:0] bx;
  logic [CW-1:0] by_coord;
  logic [CW-1:0] bz;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic [CW-1:0] cz;
  logic          last_in;

  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_in,
                  input ready);
  modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_in,
                output ready);
endinterface

// File: rtl/core/tfn_norm_if.sv
// Normal output channel: unit normal, degenerate flag and last flag.
interface tfn_norm_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfn_pkg::OUT_BITS-1:0] normal_x;
  logic signed [tfn_pkg::OUT_BITS-1:0] normal_y;
  logic signed [tfn_pkg::OUT_BITS-1:0] normal_z;
  logic                                degenerate;
  logic                                last_out;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, last_out,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, last_out,
                output ready);
endinterface

// File: rtl/core/tfn_isqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module tfn_isqrt_pipe #(
  parameter int SIDE_W = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [tfn_pkg::SUM_BITS-1:0]     in_val,
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic [tfn_pkg::ROOT_BITS-1:0]    out_root,
  output logic [SIDE_W-1:0]                out_side
);
  import tfn_pkg::*;

  logic [SUM_BITS-1:0] rem  [0:ROOT_STEPS];
  logic [SUM_BITS-1:0] rt   [0:ROOT_STEPS];
  logic                vld  [0:ROOT_STEPS];
  logic [SIDE_W-1:0]   side [0:ROOT_STEPS];

  assign rem[0]  = in_val;
  assign rt[0]   = '0;
  assign vld[0]  = in_valid;
  assign side[0] = in_side;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * k);
    logic [SUM_BITS-1:0] cand;
    logic                ge;

    assign cand = rt[k] + BIT;
    assign ge   = rem[k] >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? rem[k] - cand : rem[k];
        rt[k+1]   <= ge ? (rt[k] >> 1) + BIT : rt[k] >> 1;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[ROOT_STEPS];
  assign out_root  = ROOT_BITS'(rt[ROOT_STEPS]);
  assign out_side  = side[ROOT_STEPS];

endmodule

// File: rtl/core/triangle_face_normal_core.sv
// Top level: streaming unit face normal of one triangle per cycle while norm_out is ready.
//
// tri_in carries one triangle per transfer: vertices A, B, C in signed
// fixed point and a last flag. norm_out carries one result per triangle:
// the unit normal of (B - A) x (C - A) in signed Q1.NORMAL_FRAC_BITS,
// a degenerate flag (zero cross product, zero normal) and the last flag.
// Results leave in input order.
//
// Throughput: one triangle per cycle while norm_out is ready.
// Pipeline: edge, product, cross product, magnitude, bit length, normalize,
// square and sum registers, the 32-stage square root, division setup, the
// NORMAL_FRAC_BITS + 1 stage restoring dividers (one bit per stage), output.
//
// Reset clears every stage valid bit and holds tri_in.ready low; no result
// is pending after reset.
// When norm_out stalls with a result held, the whole pipeline holds and
// tri_in.ready drops; bubbles stay in place, nothing is lost or repeated.
// The tri_in interface width parameter must equal COORD_BITS.
module triangle_face_normal_core #(
  parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tfn_tri_if.sink   tri_in,
  tfn_norm_if.source norm_out
);
  import tfn_pkg::*;

  localparam int EDGE_SHIFT = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int EW   = COORD_BITS - EDGE_SHIFT + 1;
  localparam int PW   = 2 * EW;
  localparam int NW   = 2 * EW + 1;
  localparam int MW   = 2 * EW;
  localparam int LW   = $clog2(MW + 1);
  localparam int XW   = MW + NORM_BITS;
  localparam int F    = NORMAL_FRAC_BITS;
  localparam int DS   = F + 1;
  localparam int QW   = F + 1;
  localparam int NUMW = NORM_BITS + F + 1;
  localparam int SIDE_W = 3 * NORM_BITS + 5;
  localparam logic [QW-1:0] LIM = {1'b1, {F{1'b0}}};

  logic adv;
  logic vo;

  assign adv          = !vo || norm_out.ready;
  assign tri_in.ready = adv && !rst;

  // edges
  logic signed [COORD_BITS-1:0] pa [3];
  logic signed [COORD_BITS-1:0] pb [3];
  logic signed [COORD_BITS-1:0] pc [3];

  assign pa[0] = signed'(tri_in.ax[COORD_BITS-1:0]);
  assign pa[1] = signed'(tri_in.ay[COORD_BITS-1:0]);
  assign pa[2] = signed'(tri_in.az[COORD_BITS-1:0]);
  assign pb[0] = signed'(tri_in.bx[COORD_BITS-1:0]);
  assign pb[1] = signed'(tri_in.by_coord[COORD_BITS-1:0]);
  assign pb[2] = signed'(tri_in.bz[COORD_BITS-1:0]);
  assign pc[0] = signed'(tri_in.cx[COORD_BITS-1:0]);
  assign pc[1] = signed'(tri_in.cy[COORD_BITS-1:0]);
  assign pc[2] = signed'(tri_in.cz[COORD_BITS-1:0]);

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic                 v1, l1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= tri_in.valid;
    end
    if (adv) begin
      l1 <= tri_in.last_in;
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(((COORD_BITS + 1)'(pb[i]) - (COORD_BITS + 1)'(pa[i])) >>> EDGE_SHIFT);
        e2[i] <= EW'(((COORD_BITS + 1)'(pc[i]) - (COORD_BITS + 1)'(pa[i])) >>> EDGE_SHIFT);
      end
    end
  end

  // products
  logic signed [PW-1:0] pr [6];
  logic                 v2, l2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      l2    <= l1;
      pr[0] <= PW'(e1[1]) * PW'(e2[2]);
      pr[1] <= PW'(e1[2]) * PW'(e2[1]);
      pr[2] <= PW'(e1[2]) * PW'(e2[0]);
      pr[3] <= PW'(e1[0]) * PW'(e2[2]);
      pr[4] <= PW'(e1[0]) * PW'(e2[1]);
      pr[5] <= PW'(e1[1]) * PW'(e2[0]);
    end
  end

  // cross product
  logic signed [NW-1:0] nv [3];
  logic                 v3, l3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      l3 <= l2;
      for (int i = 0; i < 3; i++) begin
        nv[i] <= NW'(pr[2*i]) - NW'(pr[2*i+1]);
      end
    end
  end

  // magnitude and sign
  logic [MW-1:0] mag4 [3];
  logic          sg4  [3];
  logic          v4, l4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      l4 <= l3;
      for (int i = 0; i < 3; i++) begin
        sg4[i]  <= nv[i][NW-1];
        mag4[i] <= nv[i][NW-1] ? MW'(-nv[i]) : MW'(nv[i]);
      end
    end
  end

  // bit length of the largest magnitude
  logic [MW-1:0] orm;
  logic [LW-1:0] len_c;

  assign orm = mag4[0] | mag4[1] | mag4[2];

  always_comb begin
    len_c = '0;
    for (int j = 0; j < MW; j++) begin
      if (orm[j]) len_c = LW'(j + 1);
    end
  end

  logic [MW-1:0] mag5 [3];
  logic          sg5  [3];
  logic [LW-1:0] len5;
  logic          deg5, v5, l5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      l5   <= l4;
      len5 <= len_c;
      deg5 <= (orm == '0);
      mag5 <= mag4;
      sg5  <= sg4;
    end
  end

  // normalize to NORM_BITS
  logic [NORM_BITS-1:0] mn6 [3];
  logic                 sg6 [3];
  logic                 deg6, v6, l6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
    if (adv) begin
      l6   <= l5;
      deg6 <= deg5;
      sg6  <= sg5;
      for (int i = 0; i < 3; i++) begin
        mn6[i] <= NORM_BITS'(XW'({mag5[i], {NORM_BITS{1'b0}}}) >> len5);
      end
    end
  end

  // squares
  logic [2*NORM_BITS-1:0] sq7 [3];
  logic [NORM_BITS-1:0]   mn7 [3];
  logic                   sg7 [3];
  logic                   deg7, v7, l7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      l7   <= l6;
      deg7 <= deg6;
      sg7  <= sg6;
      mn7  <= mn6;
      for (int i = 0; i < 3; i++) begin
        sq7[i] <= (2 * NORM_BITS)'(mn6[i]) * (2 * NORM_BITS)'(mn6[i]);
      end
    end
  end

  // sum of squares
  logic [SUM_BITS-1:0]  sum8;
  logic [NORM_BITS-1:0] mn8 [3];
  logic                 sg8 [3];
  logic                 deg8, v8, l8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
    if (adv) begin
      l8   <= l7;
      deg8 <= deg7;
      sg8  <= sg7;
      mn8  <= mn7;
      sum8 <= SUM_BITS'(sq7[0]) + SUM_BITS'(sq7[1]) + SUM_BITS'(sq7[2]);
    end
  end

  // square root
  logic [SIDE_W-1:0]    side_in, side_out;
  logic [ROOT_BITS-1:0] root;
  logic                 vr;

  assign side_in = {mn8[0], mn8[1], mn8[2], sg8[0], sg8[1], sg8[2], deg8, l8};

  tfn_isqrt_pipe #(
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v8),
    .in_val    (sum8),
    .in_side   (side_in),
    .out_valid (vr),
    .out_root  (root),
    .out_side  (side_out)
  );

  logic [NORM_BITS-1:0] mr [3];
  logic                 sgr [3];
  logic                 degr, lr;

  assign {mr[0], mr[1], mr[2], sgr[0], sgr[1], sgr[2], degr, lr} = side_out;

  // division setup
  logic [NUMW-1:0] num [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUMW'(mr[i]) << F) + NUMW'(root >> 1);
    end
  end

  logic [ROOT_BITS-1:0] dr   [0:DS][3];
  logic [DS-1:0]        dl   [0:DS][3];
  logic [QW-1:0]        dq   [0:DS][3];
  logic                 dsg  [0:DS][3];
  logic [ROOT_BITS-1:0] dd   [0:DS];
  logic                 ddeg [0:DS];
  logic                 dlst [0:DS];
  logic                 dv   [0:DS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= vr;
    end
    if (adv) begin
      dd[0]   <= root;
      ddeg[0] <= degr;
      dlst[0] <= lr;
      for (int i = 0; i < 3; i++) begin
        dr[0][i]  <= ROOT_BITS'(num[i] >> DS);
        dl[0][i]  <= num[i][DS-1:0];
        dq[0][i]  <= '0;
        dsg[0][i] <= sgr[i];
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [ROOT_BITS:0] t  [3];
    logic               ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dr[k][i], dl[k][i][DS-1-k]};
        ge[i] = t[i] >= {1'b0, dd[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
      if (adv) begin
        dd[k+1]   <= dd[k];
        ddeg[k+1] <= ddeg[k];
        dlst[k+1] <= dlst[k];
        for (int i = 0; i < 3; i++) begin
          dr[k+1][i]  <= ge[i] ? ROOT_BITS'(t[i] - {1'b0, dd[k]}) : ROOT_BITS'(t[i]);
          dl[k+1][i]  <= dl[k][i];
          dq[k+1][i]  <= {dq[k][i][QW-2:0], ge[i]};
          dsg[k+1][i] <= dsg[k][i];
        end
      end
    end
  end

  // saturate, apply sign, zero degenerate results, output register
  logic [QW-1:0]        qsat [3];
  logic signed [QW:0]   qs   [3];
  logic [OUT_BITS-1:0]  ov   [3];
  logic                 odeg, olst;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qsat[i] = (dq[DS][i] > LIM) ? LIM : dq[DS][i];
      qs[i]   = dsg[DS][i] ? -$signed({1'b0, qsat[i]}) : $signed({1'b0, qsat[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv) begin
      vo <= dv[DS];
    end
    if (adv) begin
      odeg <= ddeg[DS];
      olst <= dlst[DS];
      for (int i = 0; i < 3; i++) begin
        ov[i] <= ddeg[DS] ? '0 : OUT_BITS'(qs[i]);
      end
    end
  end

  assign norm_out.valid      = vo;
  assign norm_out.normal_x   = signed'(ov[0]);
  assign norm_out.normal_y   = signed'(ov[1]);
  assign norm_out.normal_z   = signed'(ov[2]);
  assign norm_out.degenerate = odeg;
  assign norm_out.last_out   = olst;

endmodule

// File: bench/triangle_face_normal_core_tb.sv
// Testbench for triangle_face_normal_core: random and corner triangles, normals checked in order.
class normal_scoreboard;
  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic degen, last;
  } normal_t;

  normal_t pending[$];
  int mismatches;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void note_triangle(logic signed [15:0] p[9], logic last);
    longint e1[3], e2[3], n[3];
    logic [63:0] m[3], mx, sum, s, q;
    int len;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(p[3+i]) - longint'(p[i]);
      e2[i] = longint'(p[6+i]) - longint'(p[i]);
    end
    n[0] = e1[1]*e2[2] - e1[2]*e2[1];
    n[1] = e1[2]*e2[0] - e1[0]*e2[2];
    n[2] = e1[0]*e2[1] - e1[1]*e2[0];
    r.last = last;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = n[i] < 0 ? -n[i] : n[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1;
    end else begin
      len = 0;
      while (mx != 0) begin
        len++;
        mx = mx >> 1;
      end
      for (int i = 0; i < 3; i++)
        m[i] = len > 31 ? m[i] >> (len - 31) : m[i] << (31 - len);
      sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
      s = root64(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 14) + (s >> 1)) / s;
        if (q > (64'd1 << 14)) q = 64'd1 << 14;
        if (n[i] < 0) q = -q;
        m[i] = q;
      end
      r.nx = m[0][15:0]; r.ny = m[1][15:0]; r.nz = m[2][15:0]; r.degen = 0;
    end
    pending.push_back(r);
  endfunction

  function void check_normal(normal_t got);
    normal_t w;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected normal %0d %0d %0d", got.nx, got.ny, got.nz);
      return;
    end
    w = pending.pop_front();
    if (got.nx !== w.nx || got.ny !== w.ny || got.nz !== w.nz ||
        got.degen !== w.degen || got.last !== w.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("normal mismatch: exp %0d %0d %0d d%0b l%0b got %0d %0d %0d d%0b l%0b",
                 w.nx, w.ny, w.nz, w.degen, w.last,
                 got.nx, got.ny, got.nz, got.degen, got.last);
    end
  endfunction
endclass

module triangle_face_normal_core_tb;
  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  tfn_tri_if tri_ch ();
  tfn_norm_if norm_ch ();

  triangle_face_normal_core uut (
    .clk(clk), .rst(rst), .tri_in(tri_ch.sink), .norm_out(norm_ch.source)
  );

  normal_scoreboard board = new();
  logic signed [15:0] verts[9];
  bit stimulus_done = 0;
  int stall_mode = 0;

  function automatic logic [15:0] pick_coord(int style, logic [15:0] base);
    case (style)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 15)) - 16'd8;
      2: return 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
      default: return 16'($signed(16'($urandom_range(0, 511))) - 256);
    endcase
  endfunction

  task automatic send_triangle(logic [15:0] v[9], logic last);
    tri_ch.ax <= v[0]; tri_ch.ay <= v[1]; tri_ch.az <= v[2];
    tri_ch.bx <= v[3]; tri_ch.by_coord <= v[4]; tri_ch.bz <= v[5];
    tri_ch.cx <= v[6]; tri_ch.cy <= v[7]; tri_ch.cz <= v[8];
    tri_ch.last_in <= last;
    tri_ch.valid <= 1'b1;
    do @(posedge clk); while (!tri_ch.ready);
    for (int i = 0; i < 9; i++) verts[i] = v[i];
    board.note_triangle(verts, last);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    tri_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) norm_ch.ready <= 0;
    else case (stall_mode)
      0: norm_ch.ready <= 1;
      1: norm_ch.ready <= ($urandom_range(0, 3) != 0);
      default: norm_ch.ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && norm_ch.valid && norm_ch.ready)
      board.check_normal('{norm_ch.normal_x, norm_ch.normal_y, norm_ch.normal_z,
                           norm_ch.degenerate, norm_ch.last_out});
  end

  initial begin
    logic [15:0] v[9];
    int burst, style;
    tri_ch.valid = 0;
    tri_ch.last_in = 0;
    {tri_ch.ax, tri_ch.ay, tri_ch.az, tri_ch.bx, tri_ch.by_coord} = '0;
    {tri_ch.bz, tri_ch.cx, tri_ch.cy, tri_ch.cz} = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    v = '{default: 16'h0}; send_triangle(v, 0);
    v = '{16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0};
    send_triangle(v, 1);
    v = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0100, 16'h0, 16'h0};
    send_triangle(v, 0);
    v = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
          16'h8000, 16'h7FFF, 16'h8000};
    send_triangle(v, 0);
    v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
          16'h8000, 16'h8000, 16'h7FFF};
    send_triangle(v, 1);
    v = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
          16'h8000, 16'h8000, 16'h7FFF};
    send_triangle(v, 0);
    v = '{16'h0010, 16'h0020, 16'h0030, 16'h0020, 16'h0040, 16'h0060,
          16'h0030, 16'h0060, 16'h0090};
    send_triangle(v, 0);
    v = '{16'h1234, 16'h5678, 16'h9ABC, 16'h1234, 16'h5678, 16'h9ABC,
          16'hFFFF, 16'h0001, 16'h0002};
    send_triangle(v, 1);
    v = '{16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0001};
    send_triangle(v, 0);
    v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF,
          16'hFFFF, 16'h0, 16'h0};
    send_triangle(v, 1);
    pause_sender(1);

    for (int k = 0; k < 2000; ) begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && k < 2000; j++, k++) begin
        style = $urandom_range(0, 9);
        style = style < 5 ? 0 : style < 7 ? 3 : style < 9 ? 1 : 2;
        v[0] = pick_coord(style == 1 ? 0 : style, 16'h0);
        v[1] = pick_coord(style == 1 ? 0 : style, 16'h0);
        v[2] = pick_coord(style == 1 ? 0 : style, 16'h0);
        for (int i = 3; i < 9; i++) v[i] = pick_coord(style, v[i % 3]);
        if ($urandom_range(0, 30) == 0) begin
          for (int i = 0; i < 3; i++) v[6+i] = 16'(v[i] + (v[3+i] - v[i]) * 2);
        end
        send_triangle(v, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    tri_ch.valid <= 1'b0;
    stall_mode = 1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    stimulus_done = 1;
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    if (!stimulus_done) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule

// File: files.f
rtl/core/tfn_pkg.sv
rtl/core/tfn_tri_if.sv
rtl/core/tfn_norm_if.sv
rtl/core/tfn_isqrt_pipe.sv
rtl/core/triangle_face_normal_core.sv
bench/triangle_face_normal_core_tb.sv
